FILE: sv/observer_state_feedback_servo_assert.svh
// ----------------------------------------------------------------------------
// observer_state_feedback_servo assertion macros
// Shared concurrent assertion forms used by the servo checker.
// ----------------------------------------------------------------------------
`ifndef OBSERVER_STATE_FEEDBACK_SERVO_ASSERT_SVH
`define OBSERVER_STATE_FEEDBACK_SERVO_ASSERT_SVH

// property checked on every clock edge outside reset
`define OSFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the condition
`define OSFS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

FILE: sv/osfs_pkg.sv
// ----------------------------------------------------------------------------
// osfs_pkg
// Types, constants, saturation helper and step table of the servo sequencer.
// ----------------------------------------------------------------------------
package osfs_pkg;

  // fixed-point format of all gains
  localparam int FRAC_BITS = 13;

  localparam int DATA_W   = 16;
  localparam int DRIVE_W  = 10;
  localparam int CFG_IDX_W = 4;

  // fixed plant model and input matrix, Q13
  localparam logic signed [DATA_W-1:0] PHI11  = 16'sd8142;
  localparam logic signed [DATA_W-1:0] PHI12  = 16'sd0;
  localparam logic signed [DATA_W-1:0] PHI21  = 16'sd2041;
  localparam logic signed [DATA_W-1:0] PHI22  = 16'sd8192;
  localparam logic signed [DATA_W-1:0] GAMMA1 = 16'sd919;
  localparam logic signed [DATA_W-1:0] GAMMA2 = 16'sd115;

  localparam logic signed [DATA_W-1:0] DRIVE_MAX = 16'sd511;
  localparam logic signed [DATA_W-1:0] DRIVE_MIN = -16'sd512;

  // register reset values
  localparam logic signed [DRIVE_W-1:0] RST_REFERENCE = 10'sd255;
  localparam logic signed [DATA_W-1:0]  RST_REF_GAIN  = 16'sd14609;
  localparam logic signed [DATA_W-1:0]  RST_POS_GAIN  = 16'sd26944;
  localparam logic signed [DATA_W-1:0]  RST_VEL_GAIN  = 16'sd14608;
  localparam logic signed [DATA_W-1:0]  RST_OBS_ONE   = 16'sd16678;
  localparam logic signed [DATA_W-1:0]  RST_OBS_TWO   = 16'sd10184;
  localparam logic signed [DATA_W-1:0]  RST_DIST_GAIN = 16'sd10184;

  // number of sequencer steps per enabled sample
  localparam int NUM_STEPS = 15;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE    = 4'd0,
    REG_REFERENCE = 4'd1,
    REG_REF_GAIN  = 4'd2,
    REG_POS_GAIN  = 4'd3,
    REG_VEL_GAIN  = 4'd4,
    REG_OBS_ONE   = 4'd5,
    REG_OBS_TWO   = 4'd6,
    REG_DIST_GAIN = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } fsm_state_t;

  // accumulator-side operand
  typedef enum logic [2:0] {
    X_ZERO,
    X_ACC,
    X_Y,
    X_DRIVE,
    X_DIST
  } x_sel_t;

  // multiplier coefficient operand
  typedef enum logic [3:0] {
    A_REF_GAIN,
    A_POS_GAIN,
    A_VEL_GAIN,
    A_PHI11,
    A_PHI12,
    A_GAMMA1,
    A_OBS_ONE,
    A_PHI21,
    A_PHI22,
    A_GAMMA2,
    A_OBS_TWO,
    A_DIST_GAIN
  } a_sel_t;

  // data operand
  typedef enum logic [2:0] {
    B_REFERENCE,
    B_ONE,
    B_TWO,
    B_DIST,
    B_W,
    B_EPS
  } b_sel_t;

  // where the unit result lands besides the accumulator
  typedef enum logic [2:0] {
    D_ACC,
    D_EPS,
    D_DRIVE,
    D_W,
    D_N1,
    D_COMMIT
  } dst_t;

  typedef struct packed {
    x_sel_t x_sel;
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   mul;
    logic   neg;
    dst_t   dst;
  } uop_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic capture;
    logic step_en;
    uop_t uop;
    logic load_out;
  } seq_ctl_t;

  // saturate a wide signed value to 16 bits
  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [32:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 33'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -33'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic uop_t mk(input x_sel_t x, input a_sel_t a, input b_sel_t b,
                              input logic mul, input logic neg, input dst_t d);
    uop_t u;
    u.x_sel = x;
    u.a_sel = a;
    u.b_sel = b;
    u.mul   = mul;
    u.neg   = neg;
    u.dst   = d;
    return u;
  endfunction

  // step table: error, drive chain, disturbance sum, two observer rows, commit
  function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
    uop_t u;
    case (step)
      4'd0:  u = mk(X_Y,     A_REF_GAIN,  B_TWO,       1'b0, 1'b1, D_EPS);
      4'd1:  u = mk(X_ZERO,  A_REF_GAIN,  B_REFERENCE, 1'b1, 1'b0, D_ACC);
      4'd2:  u = mk(X_ACC,   A_POS_GAIN,  B_ONE,       1'b1, 1'b1, D_ACC);
      4'd3:  u = mk(X_ACC,   A_VEL_GAIN,  B_TWO,       1'b1, 1'b1, D_ACC);
      4'd4:  u = mk(X_ACC,   A_REF_GAIN,  B_DIST,      1'b0, 1'b1, D_DRIVE);
      4'd5:  u = mk(X_DRIVE, A_REF_GAIN,  B_DIST,      1'b0, 1'b0, D_W);
      4'd6:  u = mk(X_ZERO,  A_PHI11,     B_ONE,       1'b1, 1'b0, D_ACC);
      4'd7:  u = mk(X_ACC,   A_PHI12,     B_TWO,       1'b1, 1'b0, D_ACC);
      4'd8:  u = mk(X_ACC,   A_GAMMA1,    B_W,         1'b1, 1'b0, D_ACC);
      4'd9:  u = mk(X_ACC,   A_OBS_ONE,   B_EPS,       1'b1, 1'b0, D_N1);
      4'd10: u = mk(X_ZERO,  A_PHI21,     B_ONE,       1'b1, 1'b0, D_ACC);
      4'd11: u = mk(X_ACC,   A_PHI22,     B_TWO,       1'b1, 1'b0, D_ACC);
      4'd12: u = mk(X_ACC,   A_GAMMA2,    B_W,         1'b1, 1'b0, D_ACC);
      4'd13: u = mk(X_ACC,   A_OBS_TWO,   B_EPS,       1'b1, 1'b0, D_ACC);
      4'd14: u = mk(X_DIST,  A_DIST_GAIN, B_EPS,       1'b1, 1'b0, D_COMMIT);
      default: u = mk(X_ZERO, A_REF_GAIN, B_REFERENCE, 1'b0, 1'b0, D_ACC);
    endcase
    return u;
  endfunction

endpackage

FILE: sv/observer_state_feedback_servo.sv
// An enabled sample runs from the input transaction through 15 steps on the one shared
// multiply-accumulate unit, then loads the output register; a disabled sample goes
// straight to the output load. The sequencer takes a new sample only when idle, after
// the previous result is loaded; a stalled result holds the sequencer until the result
// transaction completes.
// Reset: registers return to their default gains, enable clears, state estimates zero.
// ----------------------------------------------------------------------------
// observer_state_feedback_servo
// Observer-based state feedback with integral action on one shared Q13 unit.
// ----------------------------------------------------------------------------
module observer_state_feedback_servo (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [osfs_pkg::DRIVE_W-1:0]   position_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [osfs_pkg::DRIVE_W-1:0]   drive,
  output logic        [osfs_pkg::DRIVE_W-1:0]   pwm_code,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [osfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [osfs_pkg::DATA_W-1:0]    cfg_data
);

  // configuration registers
  logic                                enable;
  logic signed [osfs_pkg::DRIVE_W-1:0] reference;
  logic signed [osfs_pkg::DATA_W-1:0]  ref_gain;
  logic signed [osfs_pkg::DATA_W-1:0]  pos_gain;
  logic signed [osfs_pkg::DATA_W-1:0]  vel_gain;
  logic signed [osfs_pkg::DATA_W-1:0]  obs_one;
  logic signed [osfs_pkg::DATA_W-1:0]  obs_two;
  logic signed [osfs_pkg::DATA_W-1:0]  dist_gain;

  // estimator state and scratch registers
  logic signed [osfs_pkg::DATA_W-1:0]  est_one;
  logic signed [osfs_pkg::DATA_W-1:0]  est_two;
  logic signed [osfs_pkg::DATA_W-1:0]  dist_est;
  logic signed [osfs_pkg::DATA_W-1:0]  acc;
  logic signed [osfs_pkg::DATA_W-1:0]  eps;
  logic signed [osfs_pkg::DATA_W-1:0]  w_sum;
  logic signed [osfs_pkg::DATA_W-1:0]  n1;
  logic signed [osfs_pkg::DRIVE_W-1:0] y;
  logic signed [osfs_pkg::DRIVE_W-1:0] drive_calc;
  logic signed [osfs_pkg::DRIVE_W-1:0] drive_clamp;

  logic signed [osfs_pkg::DATA_W-1:0]  op_x;
  logic signed [osfs_pkg::DATA_W-1:0]  op_a;
  logic signed [osfs_pkg::DATA_W-1:0]  op_b;
  logic signed [osfs_pkg::DATA_W-1:0]  res;

  osfs_pkg::seq_ctl_t ctl;

  osfs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .enable    (enable),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  osfs_alu u_alu (
    .x   (op_x),
    .a   (op_a),
    .b   (op_b),
    .mul (ctl.uop.mul),
    .neg (ctl.uop.neg),
    .res (res)
  );

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      reference <= osfs_pkg::RST_REFERENCE;
      ref_gain  <= osfs_pkg::RST_REF_GAIN;
      pos_gain  <= osfs_pkg::RST_POS_GAIN;
      vel_gain  <= osfs_pkg::RST_VEL_GAIN;
      obs_one   <= osfs_pkg::RST_OBS_ONE;
      obs_two   <= osfs_pkg::RST_OBS_TWO;
      dist_gain <= osfs_pkg::RST_DIST_GAIN;
    end else if (cfg_valid) begin
      case (cfg_index)
        osfs_pkg::REG_ENABLE:    enable    <= cfg_data[0];
        osfs_pkg::REG_REFERENCE: reference <= cfg_data[osfs_pkg::DRIVE_W-1:0];
        osfs_pkg::REG_REF_GAIN:  ref_gain  <= cfg_data;
        osfs_pkg::REG_POS_GAIN:  pos_gain  <= cfg_data;
        osfs_pkg::REG_VEL_GAIN:  vel_gain  <= cfg_data;
        osfs_pkg::REG_OBS_ONE:   obs_one   <= cfg_data;
        osfs_pkg::REG_OBS_TWO:   obs_two   <= cfg_data;
        osfs_pkg::REG_DIST_GAIN: dist_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand selection for the shared unit
  always_comb begin
    case (ctl.uop.x_sel)
      osfs_pkg::X_ZERO:  op_x = '0;
      osfs_pkg::X_ACC:   op_x = acc;
      osfs_pkg::X_Y:     op_x = 16'(y);
      osfs_pkg::X_DRIVE: op_x = 16'(drive_calc);
      osfs_pkg::X_DIST:  op_x = dist_est;
      default:           op_x = '0;
    endcase
    case (ctl.uop.a_sel)
      osfs_pkg::A_REF_GAIN:  op_a = ref_gain;
      osfs_pkg::A_POS_GAIN:  op_a = pos_gain;
      osfs_pkg::A_VEL_GAIN:  op_a = vel_gain;
      osfs_pkg::A_PHI11:     op_a = osfs_pkg::PHI11;
      osfs_pkg::A_PHI12:     op_a = osfs_pkg::PHI12;
      osfs_pkg::A_GAMMA1:    op_a = osfs_pkg::GAMMA1;
      osfs_pkg::A_OBS_ONE:   op_a = obs_one;
      osfs_pkg::A_PHI21:     op_a = osfs_pkg::PHI21;
      osfs_pkg::A_PHI22:     op_a = osfs_pkg::PHI22;
      osfs_pkg::A_GAMMA2:    op_a = osfs_pkg::GAMMA2;
      osfs_pkg::A_OBS_TWO:   op_a = obs_two;
      osfs_pkg::A_DIST_GAIN: op_a = dist_gain;
      default:               op_a = '0;
    endcase
    case (ctl.uop.b_sel)
      osfs_pkg::B_REFERENCE: op_b = 16'(reference);
      osfs_pkg::B_ONE:       op_b = est_one;
      osfs_pkg::B_TWO:       op_b = est_two;
      osfs_pkg::B_DIST:      op_b = dist_est;
      osfs_pkg::B_W:         op_b = w_sum;
      osfs_pkg::B_EPS:       op_b = eps;
      default:               op_b = '0;
    endcase
  end

  // drive clamp to the actuator range
  always_comb begin
    if (res > osfs_pkg::DRIVE_MAX) begin
      drive_clamp = osfs_pkg::DRIVE_MAX[osfs_pkg::DRIVE_W-1:0];
    end else if (res < osfs_pkg::DRIVE_MIN) begin
      drive_clamp = osfs_pkg::DRIVE_MIN[osfs_pkg::DRIVE_W-1:0];
    end else begin
      drive_clamp = res[osfs_pkg::DRIVE_W-1:0];
    end
  end

  // sample capture and scratch registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      y          <= position_sample;
      drive_calc <= '0;
    end else if (ctl.step_en) begin
      acc <= res;
      case (ctl.uop.dst)
        osfs_pkg::D_EPS:   eps        <= res;
        osfs_pkg::D_DRIVE: drive_calc <= drive_clamp;
        osfs_pkg::D_W:     w_sum      <= res;
        osfs_pkg::D_N1:    n1         <= res;
        default: ;
      endcase
    end
  end

  // estimator state, updated together on the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      est_one  <= '0;
      est_two  <= '0;
      dist_est <= '0;
    end else if (ctl.step_en && (ctl.uop.dst == osfs_pkg::D_COMMIT)) begin
      est_one  <= n1;
      est_two  <= acc;
      dist_est <= res;
    end
  end

  // result register, pwm code is drive offset by half scale
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      drive    <= drive_calc;
      pwm_code <= {~drive_calc[osfs_pkg::DRIVE_W-1], drive_calc[osfs_pkg::DRIVE_W-2:0]};
    end
  end

endmodule

FILE: sv/osfs_alu.sv
// ----------------------------------------------------------------------------
// osfs_alu
// Shared saturating unit: x plus or minus either a rounded Q product or b.
// ----------------------------------------------------------------------------
module osfs_alu (
  input  logic signed [osfs_pkg::DATA_W-1:0] x,
  input  logic signed [osfs_pkg::DATA_W-1:0] a,
  input  logic signed [osfs_pkg::DATA_W-1:0] b,
  input  logic                               mul,
  input  logic                               neg,
  output logic signed [osfs_pkg::DATA_W-1:0] res
);

  localparam logic signed [32:0] RND = 33'sd1 <<< (osfs_pkg::FRAC_BITS - 1);

  logic signed [31:0]                  prod;
  logic signed [32:0]                  rnd;
  logic signed [32:0]                  shifted;
  logic signed [osfs_pkg::DATA_W-1:0]  term;
  logic signed [osfs_pkg::DATA_W:0]    term_s;
  logic signed [32:0]                  sum;

  // rounded product, arithmetic shift, saturation
  always_comb begin
    prod    = a * b;
    rnd     = 33'(prod) + RND;
    shifted = rnd >>> osfs_pkg::FRAC_BITS;
    term    = mul ? osfs_pkg::sat16(shifted) : b;
  end

  // signed add or subtract with saturation
  always_comb begin
    term_s = neg ? -17'(term) : 17'(term);
    sum    = 33'(x) + 33'(term_s);
    res    = osfs_pkg::sat16(sum);
  end

endmodule

FILE: sv/osfs_seq.sv
// ----------------------------------------------------------------------------
// osfs_seq
// Sample sequencer: input handshake, step counter, output register valid.
// ----------------------------------------------------------------------------
module osfs_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 enable,
  output logic                 out_valid,
  input  logic                 out_ready,
  output osfs_pkg::seq_ctl_t   ctl
);

  osfs_pkg::fsm_state_t               state, state_next;
  logic [osfs_pkg::STEP_W-1:0]        step, step_next;
  logic                               out_valid_next;
  logic                               out_free;

  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      osfs_pkg::ST_IDLE: begin
        step_next = '0;
        if (in_valid) begin
          state_next = enable ? osfs_pkg::ST_RUN : osfs_pkg::ST_DONE;
        end
      end
      osfs_pkg::ST_RUN: begin
        if (step == osfs_pkg::LAST_STEP) begin
          state_next = osfs_pkg::ST_DONE;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      osfs_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = osfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = osfs_pkg::ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    ctl.capture  = 1'b0;
    ctl.step_en  = 1'b0;
    ctl.load_out = 1'b0;
    ctl.uop      = osfs_pkg::uop_rom(step);
    case (state)
      osfs_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      osfs_pkg::ST_RUN: begin
        ctl.step_en = 1'b1;
      end
      osfs_pkg::ST_DONE: begin
        ctl.load_out = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    if (ctl.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= osfs_pkg::ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: sv/osfs_chk.sv
// ----------------------------------------------------------------------------
// osfs_chk
// Port-level checks on the servo handshakes and result encoding.
// ----------------------------------------------------------------------------
`include "observer_state_feedback_servo_assert.svh"

module osfs_chk (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [osfs_pkg::DRIVE_W-1:0]   drive,
  input logic        [osfs_pkg::DRIVE_W-1:0]   pwm_code,
  input logic                                  cfg_ready
);

  // block goes busy after every input transaction
  `OSFS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // pwm code is the drive offset by half scale
  `OSFS_ASSERT(a_pwm_offset, !out_valid || (pwm_code == (drive ^ 10'h200)), "pwm mismatch")

  // stalled result holds
  `OSFS_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(drive), "result dropped")

  // configuration port never stalls
  `OSFS_ASSERT(a_cfg_ready, cfg_ready, "cfg stalled")

endmodule

bind observer_state_feedback_servo osfs_chk u_osfs_chk (.*);
